/* sv/sfs_pkg.sv */
// Shared types and constants of the shooter feed sequencer.
package sfs_pkg;

  localparam int unsigned InDataW  = 96;
  localparam int unsigned OutDataW = 80;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FLYWHEEL_SPEED   = 3'd0,
    REG_FEED_SPEED       = 3'd1,
    REG_SLEW_PER_MS      = 3'd2,
    REG_SHOT_INTERVAL_MS = 3'd3,
    REG_ANGLE_STEP       = 3'd4,
    REG_SETTLE_BAND      = 3'd5,
    REG_SHOT_TIMEOUT_MS  = 3'd6
  } reg_idx_t;

  localparam logic [1:0] MODE_OFF      = 2'd0;
  localparam logic [1:0] MODE_FLYWHEEL = 2'd1;
  localparam logic [1:0] MODE_SINGLE   = 2'd2;
  localparam logic [1:0] MODE_CONT     = 2'd3;

  localparam logic [1:0] REQ_SINGLE = 2'd0;
  localparam logic [1:0] REQ_DOUBLE = 2'd1;
  localparam logic [1:0] REQ_CONT   = 2'd2;

  localparam logic [1:0] DRIVE_STOP  = 2'd0;
  localparam logic [1:0] DRIVE_SPEED = 2'd1;
  localparam logic [1:0] DRIVE_ANGLE = 2'd2;
  localparam logic [1:0] DRIVE_HOLD  = 2'd3;

  localparam logic [15:0] SHOT_INTERVAL_RST = 16'd100;
  localparam logic [15:0] SHOT_TIMEOUT_RST  = 16'd500;

  localparam logic [30:0] Q_MAX_U31 = 31'h7FFF_FFFF;

  // last field in the lowest bits
  typedef struct packed {
    logic [6:0]         pad;
    logic signed [31:0] measured_angle;
    logic [1:0]         feed_request;
    logic [1:0]         requested_mode;
    logic [16:0]        flywheel_scale;
    logic               allow_feed;
    logic               allow_shoot;
    logic               halt;
    logic               online;
    logic [31:0]        now_ms;
  } in_item_t;

  typedef struct packed {
    logic [6:0]         pad;
    logic [1:0]         shots_queued;
    logic               shot_active;
    logic signed [31:0] feed_ref;
    logic [1:0]         feed_drive;
    logic [30:0]        flywheel_ref;
    logic               flywheel_enable;
    logic [1:0]         mode_out;
    logic               reference_is_angle;
    logic               control_enabled;
  } out_item_t;

endpackage

/* sv/shooter_feed_sequencer_top.sv */
// Shooter feed sequencer: flywheel reference, feeder slew and single-shot stepping.
// Each accepted item enters the input register; its result then enters the output register.
// Throughput: one item per cycle unless the output stalls; one pass of logic between them.
// While a result waits, the input register takes one more item, then the input stalls.
// Reset: synchronous, clears control state and loads register defaults
// (shot interval 100 ms, shot timeout 500 ms, all others 0).
module shooter_feed_sequencer_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // now_ms[31:0], online, halt, allow_shoot, allow_feed, flywheel_scale[16:0],
  // requested_mode[1:0], feed_request[1:0], measured_angle[31:0], zero pad
  input  logic [sfs_pkg::InDataW-1:0]         s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // control_enabled, reference_is_angle, mode_out[1:0], flywheel_enable, flywheel_ref[30:0],
  // feed_drive[1:0], feed_ref[31:0], shot_active, shots_queued[1:0], zero pad
  output logic [sfs_pkg::OutDataW-1:0]        m_axis_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sfs_pkg::CfgIdxW-1:0]         cfg_index,
  input  logic [sfs_pkg::CfgDataW-1:0]        cfg_data
);

  logic [30:0]        flywheel_speed;
  logic signed [31:0] feed_speed;
  logic [30:0]        slew_per_ms;
  logic [15:0]        shot_interval_ms;
  logic signed [31:0] angle_step;
  logic [30:0]        settle_band;
  logic [15:0]        shot_timeout_ms;

  logic [1:0]         mode_reg, mode_reg_next;
  logic signed [31:0] feed_speed_cmd, feed_speed_cmd_next;
  logic [31:0]        speed_stamp, speed_stamp_next;
  logic [31:0]        refill_stamp, refill_stamp_next;
  logic [31:0]        shot_start_stamp, shot_start_stamp_next;
  logic signed [31:0] target_angle, target_angle_next;
  logic               shot_busy, shot_busy_next;
  logic [1:0]         queued_count, queued_count_next;
  logic signed [31:0] last_feed_ref, last_feed_ref_next;

  logic                 in_valid;
  sfs_pkg::in_item_t    in_item;
  logic                 out_valid;
  sfs_pkg::out_item_t   out_item;
  sfs_pkg::out_item_t   res;
  logic                 advance;
  logic                 proc;

  logic [47:0]        fly_prod;
  logic [31:0]        fly_p;
  logic [31:0]        dt;
  logic [62:0]        slew_prod;
  logic [32:0]        lim;
  logic signed [34:0] cmd_x, tgt_x, lim_x, cmd_hi, cmd_lo, cmd_new;
  logic signed [32:0] shot_sum;
  logic signed [31:0] shot_tgt;
  logic signed [32:0] ang_err;
  logic [32:0]        ang_abs;
  logic               stop;

  assign cfg_ready     = 1'b1;
  assign advance       = !out_valid || m_axis_tready;
  assign proc          = in_valid && advance;
  assign s_axis_tready = !in_valid || advance;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      flywheel_speed   <= '0;
      feed_speed       <= '0;
      slew_per_ms      <= '0;
      shot_interval_ms <= sfs_pkg::SHOT_INTERVAL_RST;
      angle_step       <= '0;
      settle_band      <= '0;
      shot_timeout_ms  <= sfs_pkg::SHOT_TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sfs_pkg::REG_FLYWHEEL_SPEED:   flywheel_speed   <= cfg_data[30:0];
        sfs_pkg::REG_FEED_SPEED:       feed_speed       <= cfg_data;
        sfs_pkg::REG_SLEW_PER_MS:      slew_per_ms      <= cfg_data[30:0];
        sfs_pkg::REG_SHOT_INTERVAL_MS: shot_interval_ms <= cfg_data[15:0];
        sfs_pkg::REG_ANGLE_STEP:       angle_step       <= cfg_data;
        sfs_pkg::REG_SETTLE_BAND:      settle_band      <= cfg_data[30:0];
        sfs_pkg::REG_SHOT_TIMEOUT_MS:  shot_timeout_ms  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      out_item <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg         <= sfs_pkg::MODE_OFF;
      feed_speed_cmd   <= '0;
      speed_stamp      <= '0;
      refill_stamp     <= '0;
      shot_start_stamp <= '0;
      target_angle     <= '0;
      shot_busy        <= 1'b0;
      queued_count     <= '0;
      last_feed_ref    <= '0;
    end else if (proc) begin
      mode_reg         <= mode_reg_next;
      feed_speed_cmd   <= feed_speed_cmd_next;
      speed_stamp      <= speed_stamp_next;
      refill_stamp     <= refill_stamp_next;
      shot_start_stamp <= shot_start_stamp_next;
      target_angle     <= target_angle_next;
      shot_busy        <= shot_busy_next;
      queued_count     <= queued_count_next;
      last_feed_ref    <= last_feed_ref_next;
    end
  end

  // flywheel scaling
  assign fly_prod = {17'd0, flywheel_speed} * {31'd0, in_item.flywheel_scale};
  assign fly_p    = fly_prod[47:16];

  // slew limit
  assign dt        = in_item.now_ms - speed_stamp;
  assign slew_prod = {32'd0, slew_per_ms} * {31'd0, dt};
  assign lim       = ((slew_prod[62:33] != '0) || (slew_prod[32] && (slew_prod[31:0] != '0)))
                     ? {1'b1, 32'd0} : slew_prod[32:0];
  assign cmd_x  = 35'(feed_speed_cmd);
  assign tgt_x  = 35'(feed_speed);
  assign lim_x  = {2'b00, lim};
  assign cmd_hi = cmd_x + lim_x;
  assign cmd_lo = cmd_x - lim_x;

  always_comb begin
    if (tgt_x > cmd_hi) begin
      cmd_new = cmd_hi;
    end else if (tgt_x < cmd_lo) begin
      cmd_new = cmd_lo;
    end else begin
      cmd_new = tgt_x;
    end
  end

  assign shot_sum = 33'(in_item.measured_angle) + 33'(angle_step);
  assign shot_tgt = (shot_sum > 33'sd2147483647) ? 32'sh7FFF_FFFF :
                    (shot_sum < -33'sd2147483648) ? 32'sh8000_0000 : shot_sum[31:0];

  assign stop = !in_item.online || in_item.halt || !in_item.allow_shoot;

  always_comb begin
    mode_reg_next         = mode_reg;
    feed_speed_cmd_next   = feed_speed_cmd;
    speed_stamp_next      = speed_stamp;
    refill_stamp_next     = refill_stamp;
    shot_start_stamp_next = shot_start_stamp;
    target_angle_next     = target_angle;
    shot_busy_next        = shot_busy;
    queued_count_next     = queued_count;
    last_feed_ref_next    = last_feed_ref;
    ang_err               = '0;
    ang_abs               = '0;
    res                   = '0;

    if (stop) begin
      mode_reg_next         = sfs_pkg::MODE_OFF;
      shot_busy_next        = 1'b0;
      queued_count_next     = '0;
      feed_speed_cmd_next   = '0;
      speed_stamp_next      = '0;
      shot_start_stamp_next = '0;
      last_feed_ref_next    = '0;
    end else begin
      res.control_enabled    = 1'b1;
      res.reference_is_angle = (in_item.feed_request != sfs_pkg::REQ_CONT);
      mode_reg_next          = in_item.requested_mode;
      if (in_item.requested_mode != sfs_pkg::MODE_OFF) begin
        res.flywheel_enable = 1'b1;
        res.flywheel_ref    = fly_p[31] ? sfs_pkg::Q_MAX_U31 : fly_p[30:0];
      end
      if (!in_item.allow_feed || in_item.requested_mode == sfs_pkg::MODE_OFF ||
          in_item.requested_mode == sfs_pkg::MODE_FLYWHEEL) begin
        shot_busy_next      = 1'b0;
        queued_count_next   = '0;
        feed_speed_cmd_next = '0;
        speed_stamp_next    = in_item.now_ms;
        last_feed_ref_next  = '0;
      end else if (in_item.requested_mode == sfs_pkg::MODE_CONT) begin
        speed_stamp_next = in_item.now_ms;
        if (speed_stamp == '0) begin
          feed_speed_cmd_next = feed_speed;
        end else if (cmd_new > 35'sd2147483647) begin
          feed_speed_cmd_next = 32'sh7FFF_FFFF;
        end else if (cmd_new < -35'sd2147483648) begin
          feed_speed_cmd_next = 32'sh8000_0000;
        end else begin
          feed_speed_cmd_next = cmd_new[31:0];
        end
        res.feed_drive     = sfs_pkg::DRIVE_SPEED;
        last_feed_ref_next = feed_speed_cmd_next;
        shot_busy_next     = 1'b0;
        queued_count_next  = '0;
      end else begin
        if ((in_item.now_ms - refill_stamp) >= {16'd0, shot_interval_ms}) begin
          queued_count_next = (in_item.feed_request == sfs_pkg::REQ_DOUBLE) ? 2'd2 : 2'd1;
          refill_stamp_next = in_item.now_ms;
        end
        if (!shot_busy && queued_count_next != '0) begin
          target_angle_next     = shot_tgt;
          queued_count_next     = queued_count_next - 2'd1;
          shot_busy_next        = 1'b1;
          shot_start_stamp_next = in_item.now_ms;
        end
        if (shot_busy_next) begin
          ang_err            = 33'(in_item.measured_angle) - 33'(target_angle_next);
          ang_abs            = ang_err[32] ? 33'(-ang_err) : ang_err;
          res.feed_drive     = sfs_pkg::DRIVE_ANGLE;
          last_feed_ref_next = target_angle_next;
          if (ang_abs <= {2'b00, settle_band} ||
              (in_item.now_ms - shot_start_stamp_next) >= {16'd0, shot_timeout_ms}) begin
            shot_busy_next = 1'b0;
          end
        end else begin
          res.feed_drive     = sfs_pkg::DRIVE_HOLD;
          last_feed_ref_next = '0;
        end
        feed_speed_cmd_next = '0;
        speed_stamp_next    = in_item.now_ms;
      end
    end

    res.mode_out     = mode_reg_next;
    res.feed_ref     = last_feed_ref_next;
    res.shot_active  = shot_busy_next;
    res.shots_queued = queued_count_next;
  end

  a_stop_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.control_enabled |->
      out_item.mode_out == sfs_pkg::MODE_OFF && out_item.feed_ref == '0 &&
      !out_item.flywheel_enable && out_item.feed_drive == sfs_pkg::DRIVE_STOP &&
      !out_item.shot_active && out_item.shots_queued == '0)
    else $error("stopped item carries nonzero fields");

  a_busy_single: assert property (@(posedge clk) disable iff (rst)
    shot_busy |-> mode_reg == sfs_pkg::MODE_SINGLE)
    else $error("shot busy outside single mode");

  a_queue_range: assert property (@(posedge clk) disable iff (rst)
    queued_count != 2'd3)
    else $error("shot queue overflow");

  a_hold_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_item))
    else $error("held input item lost");

endmodule
